// ===== hw/rtl/sgdmf_pkg.sv =====
// Package for the matrix factorization update block: widths, opcodes, register map,
// fixed point helpers. No dependencies.
package sgdmf_pkg;
	localparam int MAX_FEATURES_D = 32;
	localparam int USER_ROWS_D    = 1024;
	localparam int ITEM_ROWS_D    = 1024;

	localparam int OP_W   = 3;
	localparam int UIDX_W = 10;
	localparam int IIDX_W = 10;
	localparam int FIDX_W = 5;
	localparam int VAL_W  = 32;
	localparam int FCNT_W = 6;
	localparam int FRAC_W = 16;
	localparam int PADDR_W = 4;

	localparam logic [OP_W-1:0] OP_TRAIN     = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_USER = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_ITEM = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_USER = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_ITEM = 3'd4;

	localparam logic [PADDR_W-1:0] REG_FCNT = 4'h0;
	localparam logic [PADDR_W-1:0] REG_RATE = 4'h4;
	localparam logic [PADDR_W-1:0] REG_REG  = 4'h8;

	localparam logic [FCNT_W-1:0] FCNT_RST = 6'd32;
	localparam logic [FRAC_W-1:0] RATE_RST = 16'd655;
	localparam logic [FRAC_W-1:0] REG_RST  = 16'd3277;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [UIDX_W-1:0] user_index;
		logic [IIDX_W-1:0] item_index;
		logic [FIDX_W-1:0] feature_index;
		logic signed [VAL_W-1:0] operand_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] result_value;
		logic saturated;
	} rsp_t;

	// round Q.16 product: add half, arithmetic shift by 16
	function automatic logic signed [48:0] rnd16(input logic signed [64:0] p);
		logic signed [64:0] t;
		t = (p + 65'sd32768) >>> 16;
		return t[48:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v,
		output logic f);
		f = 1'b0;
		if (v > 56'sd2147483647) begin
			f = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -56'sd2147483648) begin
			f = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage

// ===== hw/rtl/sgdmf_if.sv =====
// Valid/ready channel carrying one word of a given struct type.
// No dependencies; the payload type is given as a parameter.
interface sgdmf_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sgdmf_ram.sv =====
// Generic single port synchronous RAM with registered read.
// No dependencies.
module sgdmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/sgdmf_regs.sv =====
// APB register file for feature count, learning rate and regularization.
// Depends on sgdmf_pkg.
module sgdmf_regs
	import sgdmf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [FCNT_W-1:0] fcnt,
	output logic [FRAC_W-1:0] rate,
	output logic [FRAC_W-1:0] regf
);
	logic wr;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcnt <= FCNT_RST;
			rate <= RATE_RST;
			regf <= REG_RST;
		end else if (wr) begin
			unique case (paddr)
				REG_FCNT: fcnt <= pwdata[FCNT_W-1:0];
				REG_RATE: rate <= pwdata[FRAC_W-1:0];
				REG_REG:  regf <= pwdata[FRAC_W-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			REG_FCNT: prdata = {26'd0, fcnt};
			REG_RATE: prdata = {16'd0, rate};
			REG_REG:  prdata = {16'd0, regf};
			default:  prdata = '0;
		endcase
	end
endmodule

// ===== hw/rtl/sgdmf_core.sv =====
// Sequencer: train reads, updates and writes back both feature tables; load and read access one table entry.
// Depends on sgdmf_pkg, sgdmf_if and sgdmf_ram.
module sgdmf_core
	import sgdmf_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_D,
	parameter int USER_ROWS    = USER_ROWS_D,
	parameter int ITEM_ROWS    = ITEM_ROWS_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [FCNT_W-1:0] fcnt,
	input  logic [FRAC_W-1:0] rate,
	input  logic [FRAC_W-1:0] regf,
	sgdmf_if.sink   req,
	sgdmf_if.source rsp
);
	localparam int FW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FCW = $clog2(MAX_FEATURES + 1);
	localparam int URW = $clog2(USER_ROWS);
	localparam int IRW = $clog2(ITEM_ROWS);
	localparam int UAW = $clog2(USER_ROWS * MAX_FEATURES);
	localparam int IAW = $clog2(ITEM_ROWS * MAX_FEATURES);

	localparam logic [3:0] S_IDLE = 4'd0, S_DRD = 4'd1, S_DMUL = 4'd2, S_DACC = 4'd3,
		S_ERR = 4'd4, S_URD = 4'd5, S_G1 = 4'd6, S_G2 = 4'd7, S_ST = 4'd8,
		S_WB = 4'd9, S_SRD = 4'd10, S_SOUT = 4'd11, S_OUT = 4'd12, S_UAD = 4'd13;

	logic [3:0] state_q;
	req_t r_q;
	logic [FCW-1:0] n_q, f_q;
	logic signed [55:0] acc_q;
	logic signed [31:0] err_q, u_q, i_q, gu_q, gi_q, res_q;
	logic signed [48:0] pa_q, pb_q, pc_q, pd_q;
	logic ov_q;
	logic ue, ie;
	logic [UAW-1:0] ua;
	logic [IAW-1:0] ia;
	logic [31:0] uw, iw, ur, ir;
	logic [URW-1:0] urow;
	logic [IRW-1:0] irow;
	logic [FW-1:0] fsel;
	logic signed [31:0] nu, ni, gus, gis, e_sat;
	logic f1, f2, f3, f4, f5;

	assign urow = URW'(r_q.user_index % USER_ROWS);
	assign irow = IRW'(r_q.item_index % ITEM_ROWS);
	always_comb begin
		if (state_q == S_IDLE || state_q == S_SRD || state_q == S_SOUT)
			fsel = FW'(r_q.feature_index % MAX_FEATURES);
		else
			fsel = f_q[FW-1:0];
	end
	assign ua = UAW'(urow * MAX_FEATURES) + UAW'(fsel);
	assign ia = IAW'(irow * MAX_FEATURES) + IAW'(fsel);

	sgdmf_ram #(.WIDTH(32), .DEPTH(USER_ROWS * MAX_FEATURES)) u_user (
		.clk(clk), .we(ue), .addr(ua), .wdata(uw), .rdata(ur));
	sgdmf_ram #(.WIDTH(32), .DEPTH(ITEM_ROWS * MAX_FEATURES)) u_item (
		.clk(clk), .we(ie), .addr(ia), .wdata(iw), .rdata(ir));

	always_comb begin
		e_sat = sat32(acc_q, f1);
		gus = sat32(56'(pa_q) + 56'(pb_q), f2);
		gis = sat32(56'(pc_q) + 56'(pb_q), f3);
		nu = sat32(56'(u_q) - 56'(pa_q), f4);
		ni = sat32(56'(i_q) - 56'(pc_q), f5);
	end

	always_comb begin
		ue = 1'b0;
		ie = 1'b0;
		uw = r_q.operand_value;
		iw = r_q.operand_value;
		if (state_q == S_WB) begin
			ue = 1'b1;
			ie = 1'b1;
			uw = nu;
			iw = ni;
		end else if (state_q == S_SRD) begin
			ue = r_q.operation == OP_LOAD_USER;
			ie = r_q.operation == OP_LOAD_ITEM;
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = state_q == S_OUT;
	assign rsp.data.result_value = res_q;
	assign rsp.data.saturated = ov_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (req.valid) r_q <= req.data;
			S_DMUL: pa_q <= rnd16(65'(64'(signed'(ur)) * 64'(signed'(ir))));
			S_URD: begin
				u_q <= ur;
				i_q <= ir;
				pa_q <= rnd16(65'(64'(signed'({1'b0, regf})) * 64'(signed'(ur))));
				pc_q <= rnd16(65'(64'(signed'({1'b0, regf})) * 64'(signed'(ir))));
				pb_q <= rnd16(65'(64'(err_q) * 64'(signed'(ir))));
				pd_q <= rnd16(65'(64'(err_q) * 64'(signed'(ur))));
			end
			S_G1: begin
				gu_q <= gus;
				pb_q <= pd_q;
			end
			S_G2: gi_q <= gis;
			S_ST: begin
				pa_q <= rnd16(65'(64'(signed'({1'b0, rate})) * 64'(gu_q)));
				pc_q <= rnd16(65'(64'(signed'({1'b0, rate})) * 64'(gi_q)));
			end
			S_SOUT: begin
				case (r_q.operation) inside
					OP_LOAD_USER, OP_LOAD_ITEM: res_q <= r_q.operand_value;
					OP_READ_USER: res_q <= ur;
					OP_READ_ITEM: res_q <= ir;
					default: res_q <= '0;
				endcase
			end
			S_ERR: res_q <= e_sat;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			f_q <= '0;
			acc_q <= '0;
			err_q <= '0;
			ov_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					n_q <= (32'(fcnt) > MAX_FEATURES) ? FCW'(MAX_FEATURES) : FCW'(fcnt);
					f_q <= '0;
					acc_q <= -56'(req.data.operand_value);
					state_q <= (req.data.operation == OP_TRAIN) ? S_DRD : S_SRD;
				end
				S_DRD: state_q <= (f_q < n_q) ? S_DMUL : S_ERR;
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					acc_q <= acc_q + 56'(pa_q);
					f_q <= f_q + 1'b1;
					state_q <= S_DRD;
				end
				S_ERR: begin
					err_q <= e_sat;
					ov_q <= f1;
					f_q <= '0;
					state_q <= (n_q == '0) ? S_OUT : S_UAD;
				end
				S_UAD: state_q <= S_URD;
				S_URD: state_q <= S_G1;
				S_G1: begin
					ov_q <= ov_q | f2;
					state_q <= S_G2;
				end
				S_G2: begin
					ov_q <= ov_q | f3;
					state_q <= S_ST;
				end
				S_ST: state_q <= S_WB;
				S_WB: begin
					ov_q <= ov_q | f4 | f5;
					if (f_q + 1'b1 < n_q) begin
						f_q <= f_q + 1'b1;
						state_q <= S_UAD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_SRD: state_q <= S_SOUT;
				S_SOUT: begin
					ov_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data));
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid));
	a_state_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q <= S_UAD);
	a_feat_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= FCW'(MAX_FEATURES) && f_q <= n_q);
endmodule

// ===== hw/rtl/sgd_matrix_factor_update.sv =====
// Top level of the matrix factorization update block: registers and core.
// Depends on sgdmf_pkg, sgdmf_if, sgdmf_regs, sgdmf_core.
//  channel | dir | payload
//  req     | in  | operation, user_index, item_index, feature_index, operand_value
//  rsp     | out | result_value, saturated
//  apb     | in  | feature count, step rate, regularization
// Train computes the dot product over n features, then updates each of the
// n features (none when n is zero), then presents the result and returns to
// idle; each table has one port, one access per cycle.
// Reset clears control only; tables hold garbage until loaded.
// The block takes one word at a time and waits while the result is stalled.
module sgd_matrix_factor_update
	import sgdmf_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_D,
	parameter int USER_ROWS    = USER_ROWS_D,
	parameter int ITEM_ROWS    = ITEM_ROWS_D
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	sgdmf_if.sink   req,
	sgdmf_if.source rsp
);
	logic [FCNT_W-1:0] fcnt;
	logic [FRAC_W-1:0] rate, regf;

	sgdmf_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .fcnt, .rate, .regf);

	sgdmf_core #(.MAX_FEATURES(MAX_FEATURES), .USER_ROWS(USER_ROWS),
		.ITEM_ROWS(ITEM_ROWS)) u_core (.clk, .arst_n, .fcnt, .rate, .regf,
		.req(req), .rsp(rsp));
endmodule
